// ===== rtl/hes_pkg.sv =====
package hes_pkg;

    // Default geometry of the histogram.
    localparam int unsigned BIN_COUNT_DEF  = 16;
    localparam int unsigned COUNT_BITS_DEF = 24;

    // Fixed field widths.
    localparam int unsigned LVL_W  = 16;
    localparam int unsigned FT_W   = 16;
    localparam int unsigned APB_AW = 4;
    localparam int unsigned APB_DW = 32;

    // One in Q1.16, the saturation point of the blend weight.
    localparam logic [16:0] ONE_Q16 = 17'h10000;

    // Register reset values.
    localparam logic [15:0] MAX_LEVEL_RST  = 16'd16384;
    localparam logic [15:0] ADAPT_RATE_RST = 16'd8192;
    localparam logic [15:0] PCT_TARGET_RST = 16'd62259;
    localparam logic [15:0] BLOOM_FRAC_RST = 16'd32768;

    // Smoothed level reset values.
    localparam logic [15:0] SM_MEAN_RST  = 16'd0;
    localparam logic [15:0] SM_PEAK_RST  = 16'd4096;
    localparam logic [15:0] SM_KEY_RST   = 16'd4096;
    localparam logic [15:0] SM_BLOOM_RST = 16'd0;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        REG_MAX_LEVEL,
        REG_ADAPT_RATE,
        REG_PCT_TARGET,
        REG_BLOOM_FRAC
    } t_reg_idx;

    // Configuration as seen by the back end.
    typedef struct packed {
        logic [15:0] max_level;
        logic [15:0] adapt_rate;
        logic [15:0] percentile_target;
        logic [15:0] bloom_fraction;
    } t_cfg;

    // Handshake between the front end, the frame queue and the back end.
    typedef struct packed {
        logic full;
        logic valid;
    } t_q_stat;

endpackage

// ===== rtl/hes_if.sv =====
interface hes_bin_if #(
    parameter int unsigned COUNT_BITS = hes_pkg::COUNT_BITS_DEF
);
    import hes_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [COUNT_BITS-1:0] bin_count;
    logic                  last_bin;
    logic [FT_W-1:0]       frame_time;

    modport source (output valid, bin_count, last_bin, frame_time, input ready);
    modport sink   (input valid, bin_count, last_bin, frame_time, output ready);
endinterface

interface hes_lvl_if;
    import hes_pkg::*;

    logic             valid;
    logic             ready;
    logic [LVL_W-1:0] mean_level;
    logic [LVL_W-1:0] peak_level;
    logic [LVL_W-1:0] key_level;
    logic [LVL_W-1:0] bloom_level;
    logic             empty_frame;

    modport source (output valid, mean_level, peak_level, key_level, bloom_level, empty_frame,
                    input ready);
    modport sink   (input valid, mean_level, peak_level, key_level, bloom_level, empty_frame,
                    output ready);
endinterface

// ===== rtl/hes_queue.sv =====
module hes_queue #(
    parameter int unsigned W = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  logic                  i_pop,
    input  logic [W-1:0]          i_data,
    output hes_pkg::t_q_stat      o_stat,
    output logic [W-1:0]          o_head
);
    import hes_pkg::*;

    logic [W-1:0] r_slot [2];
    logic         r_wr;
    logic         r_rd;
    logic [1:0]   r_cnt;

    // Two frames can wait: one under processing, one just closed.
    assign o_stat.full  = (r_cnt == 2'd2);
    assign o_stat.valid = (r_cnt != 2'd0);
    assign o_head       = r_slot[r_rd];

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    // Frame summary storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr] <= i_data;
        end
    end

endmodule

// ===== rtl/hes_front.sv =====
module hes_front #(
    parameter int unsigned BIN_COUNT  = hes_pkg::BIN_COUNT_DEF,
    parameter int unsigned COUNT_BITS = hes_pkg::COUNT_BITS_DEF,
    localparam int unsigned IDX_W = $clog2(BIN_COUNT),
    localparam int unsigned TOT_W = COUNT_BITS + IDX_W,
    localparam int unsigned WGT_W = COUNT_BITS + 2 * IDX_W,
    localparam int unsigned JOB_W = 1 + IDX_W + TOT_W + WGT_W + IDX_W + hes_pkg::FT_W
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    hes_bin_if.sink               i_bin,
    input  hes_pkg::t_q_stat      i_q_stat,
    output logic                  o_push,
    output logic [JOB_W-1:0]      o_job,
    output logic                  o_wr_en,
    output logic [IDX_W:0]        o_wr_addr,
    output logic [COUNT_BITS-1:0] o_wr_data
);
    import hes_pkg::*;

    localparam int unsigned PROD_W = COUNT_BITS + IDX_W;

    logic               r_bank;
    logic [IDX_W-1:0]   r_pos;
    logic [TOT_W-1:0]   r_total;
    logic [WGT_W-1:0]   r_wgt;
    logic [IDX_W-1:0]   r_top;

    logic               accept;
    logic               first;
    logic [PROD_W-1:0]  prod;
    logic [TOT_W-1:0]   n_total;
    logic [WGT_W-1:0]   n_wgt;
    logic [IDX_W-1:0]   n_top;

    // A word is taken whenever a queue slot is free for the frame it may close.
    assign i_bin.ready = !i_q_stat.full;
    assign accept      = i_bin.valid && !i_q_stat.full;
    assign first       = (r_pos == '0);

    // Running sums restart at bin zero, so a wrapped frame only counts its last pass.
    assign prod    = PROD_W'(i_bin.bin_count) * PROD_W'(r_pos);
    assign n_total = (first ? '0 : r_total) + TOT_W'(i_bin.bin_count);
    assign n_wgt   = (first ? '0 : r_wgt) + WGT_W'(prod);
    assign n_top   = (i_bin.bin_count != '0) ? r_pos : (first ? '0 : r_top);

    // Bin store write port and frame hand-off.
    assign o_wr_en   = accept;
    assign o_wr_addr = {r_bank, r_pos};
    assign o_wr_data = i_bin.bin_count;
    assign o_push    = accept && i_bin.last_bin;
    assign o_job     = {r_bank, r_pos, n_total, n_wgt, n_top, i_bin.frame_time};

    // Bin position and bank select.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank <= 1'b0;
            r_pos  <= '0;
        end else if (accept) begin
            if (i_bin.last_bin) begin
                r_pos  <= '0;
                r_bank <= ~r_bank;
            end else if (r_pos == IDX_W'(BIN_COUNT - 1)) begin
                r_pos <= '0;
            end else begin
                r_pos <= r_pos + 1'b1;
            end
        end
    end

    // Frame accumulators.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_total <= n_total;
            r_wgt   <= n_wgt;
            r_top   <= n_top;
        end
    end

endmodule

// ===== rtl/hes_back.sv =====
module hes_back #(
    parameter int unsigned BIN_COUNT  = hes_pkg::BIN_COUNT_DEF,
    parameter int unsigned COUNT_BITS = hes_pkg::COUNT_BITS_DEF,
    localparam int unsigned IDX_W = $clog2(BIN_COUNT),
    localparam int unsigned TOT_W = COUNT_BITS + IDX_W,
    localparam int unsigned WGT_W = COUNT_BITS + 2 * IDX_W,
    localparam int unsigned JOB_W = 1 + IDX_W + TOT_W + WGT_W + IDX_W + hes_pkg::FT_W
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  hes_pkg::t_cfg         i_cfg,
    input  logic                  i_wr_en,
    input  logic [IDX_W:0]        i_wr_addr,
    input  logic [COUNT_BITS-1:0] i_wr_data,
    input  hes_pkg::t_q_stat      i_q_stat,
    input  logic [JOB_W-1:0]      i_job,
    output logic                  o_pop,
    hes_lvl_if.source             o_lvl
);
    import hes_pkg::*;

    localparam int unsigned NW    = COUNT_BITS + 2 * IDX_W + LVL_W;
    localparam int unsigned TG_W  = TOT_W + 17;
    localparam int unsigned KN_W  = IDX_W + 1 + LVL_W;
    localparam int unsigned PN_W  = IDX_W + LVL_W;
    localparam int unsigned DM_W  = TOT_W + IDX_W + 1;
    localparam int unsigned CNT_W = $clog2(LVL_W);
    localparam int unsigned DEPTH = 2 ** (IDX_W + 1);

    // Division by the bin count as a multiply by its rounded-up reciprocal.
    // The result is exact for every dividend below 2^SC_N.
    localparam int unsigned     SC_N  = KN_W;
    localparam int unsigned     SC_S  = SC_N + IDX_W;
    localparam int unsigned     RCP_W = SC_N + 2;
    localparam int unsigned     SC_W  = SC_N + RCP_W;
    localparam longint unsigned RCP   =
        ((64'd1 << SC_S) + 64'(BIN_COUNT) - 64'd1) / 64'(BIN_COUNT);

    typedef enum logic [2:0] {
        S_IDLE,
        S_KRD,
        S_KCHK,
        S_DIV,
        S_MUL,
        S_BLOOM,
        S_BLEND,
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        DV_KEY,
        DV_PEAK,
        DV_MEAN
    } t_dsel;

    typedef enum logic [1:0] {
        LV_MEAN,
        LV_PEAK,
        LV_KEY,
        LV_BLOOM
    } t_lvl_sel;

    // Head frame summary, stable until it is popped.
    logic               j_bank;
    logic [IDX_W-1:0]   j_pos;
    logic [TOT_W-1:0]   j_total;
    logic [WGT_W-1:0]   j_wgt;
    logic [IDX_W-1:0]   j_top;
    logic [FT_W-1:0]    j_ft;

    logic [COUNT_BITS-1:0] r_mem [DEPTH];
    logic [COUNT_BITS-1:0] r_rdata;

    t_state             r_state;
    t_dsel              r_dsel;
    t_lvl_sel           r_lsel;
    logic [16:0]        r_t;
    logic [TG_W-1:0]    r_target;
    logic [IDX_W-1:0]   r_k;
    logic [TOT_W-1:0]   r_cum;
    logic [NW-1:0]      r_rem;
    logic [NW-1:0]      r_dsh;
    logic [NW-1:0]      r_mcand;
    logic [LVL_W-1:0]   r_mplier;
    logic [LVL_W-1:0]   r_q;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_empty;
    logic [LVL_W-1:0]   r_mean;
    logic [LVL_W-1:0]   r_peak;
    logic [LVL_W-1:0]   r_key;
    logic [LVL_W-1:0]   r_bloom;
    logic [LVL_W-1:0]   r_sm_mean;
    logic [LVL_W-1:0]   r_sm_peak;
    logic [LVL_W-1:0]   r_sm_key;
    logic [LVL_W-1:0]   r_sm_bloom;
    logic               r_o_valid;
    logic [LVL_W-1:0]   r_o_mean;
    logic [LVL_W-1:0]   r_o_peak;
    logic [LVL_W-1:0]   r_o_key;
    logic [LVL_W-1:0]   r_o_bloom;
    logic               r_o_empty;

    logic [31:0]        t_prod;
    logic [19:0]        t_raw;
    logic [16:0]        t_sat;
    logic [TG_W-1:0]    target;
    logic [TOT_W-1:0]   cum_n;
    logic               hit;
    logic [IDX_W:0]     kp1;
    logic [NW-1:0]      key_n;
    logic [NW-1:0]      peak_n;
    logic [SC_W-1:0]    sc_prod;
    logic [LVL_W-1:0]   sc_lvl;
    logic [DM_W-1:0]    d_mean;
    logic               ge;
    logic [LVL_W-1:0]   q_next;
    logic [31:0]        bloom_prod;
    logic [LVL_W-1:0]   bl_old;
    logic [LVL_W-1:0]   bl_val;
    logic signed [17:0] bl_diff;
    logic signed [35:0] bl_acc;
    logic [LVL_W-1:0]   bl_res;
    logic               out_free;

    assign {j_bank, j_pos, j_total, j_wgt, j_top, j_ft} = i_job;

    // Blend weight: frame time times adaptation rate, saturated at one.
    assign t_prod = 32'(j_ft) * 32'(i_cfg.adapt_rate);
    assign t_raw  = t_prod[31:12];
    assign t_sat  = (t_raw > 20'(ONE_Q16)) ? ONE_Q16 : t_raw[16:0];

    // Percentile threshold scaled by 2^16 to match the shifted running count.
    assign target = TG_W'(j_total) * TG_W'(ONE_Q16 - {1'b0, i_cfg.percentile_target});
    assign cum_n  = r_cum + TOT_W'(r_rdata);
    assign hit    = (TG_W'({cum_n, 16'b0}) >= r_target) || (r_k == '0);

    // Operands for the key, peak and mean levels.
    assign kp1    = {1'b0, r_k} + 1'b1;
    assign key_n  = NW'(KN_W'(kp1) * KN_W'(i_cfg.max_level));
    assign peak_n = NW'(PN_W'(j_top) * PN_W'(i_cfg.max_level));
    assign d_mean = DM_W'(j_total) * DM_W'(BIN_COUNT);

    // Key and peak levels: the registered product divided by the bin count.
    assign sc_prod = SC_W'(r_rem[SC_N-1:0]) * SC_W'(RCP);
    assign sc_lvl  = sc_prod[SC_S +: LVL_W];

    // One restoring division step per cycle for the mean level.
    assign ge     = (r_rem >= r_dsh);
    assign q_next = {r_q[LVL_W-2:0], ge};

    assign bloom_prod = 32'(r_key) * 32'(i_cfg.bloom_fraction);

    // Blend old + (new - old) * t with rounding, one level per cycle.
    always_comb begin
        case (r_lsel)
            LV_MEAN:  begin bl_old = r_sm_mean;  bl_val = r_mean;  end
            LV_PEAK:  begin bl_old = r_sm_peak;  bl_val = r_peak;  end
            LV_KEY:   begin bl_old = r_sm_key;   bl_val = r_key;   end
            LV_BLOOM: begin bl_old = r_sm_bloom; bl_val = r_bloom; end
            default:  begin bl_old = r_sm_mean;  bl_val = r_mean;  end
        endcase
    end

    assign bl_diff = $signed({2'b00, bl_val}) - $signed({2'b00, bl_old});
    assign bl_acc  = $signed({4'b0000, bl_old, 16'h0000}) + bl_diff * $signed({1'b0, r_t})
                   + 36'sd32768;
    assign bl_res  = bl_acc[31:16];

    // Result register is free when empty or being taken this cycle.
    assign out_free = !r_o_valid || o_lvl.ready;
    assign o_pop    = (r_state == S_OUT) && out_free;

    assign o_lvl.valid       = r_o_valid;
    assign o_lvl.mean_level  = r_o_mean;
    assign o_lvl.peak_level  = r_o_peak;
    assign o_lvl.key_level   = r_o_key;
    assign o_lvl.bloom_level = r_o_bloom;
    assign o_lvl.empty_frame = r_o_empty;

    // Bin store: written by the front end, read here during the key scan.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rdata <= r_mem[{j_bank, r_k}];
    end

    // Frame sequencer and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_o_valid  <= 1'b0;
            r_sm_mean  <= SM_MEAN_RST;
            r_sm_peak  <= SM_PEAK_RST;
            r_sm_key   <= SM_KEY_RST;
            r_sm_bloom <= SM_BLOOM_RST;
        end else begin
            // A new word is loaded on pop; otherwise a taken word empties the register.
            if (o_pop) begin
                r_o_valid <= 1'b1;
            end else if (r_o_valid && o_lvl.ready) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_q_stat.valid) begin
                        r_t      <= t_sat;
                        r_target <= target;
                        r_k      <= j_pos;
                        r_cum    <= '0;
                        r_empty  <= (j_total == '0);
                        r_state  <= (j_total == '0) ? S_OUT : S_KRD;
                    end
                end
                S_KRD: begin
                    r_state <= S_KCHK;
                end
                S_KCHK: begin
                    // Walk down from the top bin until the upper tail is large enough.
                    if (hit) begin
                        r_rem   <= key_n;
                        r_dsel  <= DV_KEY;
                        r_state <= S_DIV;
                    end else begin
                        r_cum   <= cum_n;
                        r_k     <= r_k - 1'b1;
                        r_state <= S_KRD;
                    end
                end
                S_DIV: begin
                    case (r_dsel)
                        DV_KEY: begin
                            r_key  <= sc_lvl;
                            r_rem  <= peak_n;
                            r_dsel <= DV_PEAK;
                        end
                        DV_PEAK: begin
                            r_peak   <= sc_lvl;
                            r_rem    <= '0;
                            r_mcand  <= NW'(j_wgt);
                            r_mplier <= i_cfg.max_level;
                            r_cnt    <= '0;
                            r_state  <= S_MUL;
                        end
                        DV_MEAN: begin
                            if (ge) begin
                                r_rem <= r_rem - r_dsh;
                            end
                            r_dsh <= r_dsh >> 1;
                            r_q   <= q_next;
                            r_cnt <= r_cnt + 1'b1;
                            if (r_cnt == CNT_W'(LVL_W - 1)) begin
                                r_mean  <= q_next;
                                r_state <= S_BLOOM;
                            end
                        end
                        default: begin
                            r_state <= S_BLOOM;
                        end
                    endcase
                end
                S_MUL: begin
                    // Shift-add product of weighted sum and max level.
                    if (r_mplier[0]) begin
                        r_rem <= r_rem + r_mcand;
                    end
                    r_mcand  <= r_mcand << 1;
                    r_mplier <= r_mplier >> 1;
                    r_cnt    <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(LVL_W - 1)) begin
                        r_dsh   <= NW'(d_mean) << (LVL_W - 1);
                        r_q     <= '0;
                        r_dsel  <= DV_MEAN;
                        r_state <= S_DIV;
                    end
                end
                S_BLOOM: begin
                    r_bloom <= bloom_prod[31:16];
                    r_lsel  <= LV_MEAN;
                    r_state <= S_BLEND;
                end
                S_BLEND: begin
                    case (r_lsel)
                        LV_MEAN:  r_sm_mean  <= bl_res;
                        LV_PEAK:  r_sm_peak  <= bl_res;
                        LV_KEY:   r_sm_key   <= bl_res;
                        LV_BLOOM: r_sm_bloom <= bl_res;
                        default:  r_sm_mean  <= bl_res;
                    endcase
                    if (r_lsel == LV_BLOOM) begin
                        r_state <= S_OUT;
                    end else begin
                        r_lsel <= t_lvl_sel'(r_lsel + 2'd1);
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_o_mean  <= r_sm_mean;
                        r_o_peak  <= r_sm_peak;
                        r_o_key   <= r_sm_key;
                        r_o_bloom <= r_sm_bloom;
                        r_o_empty <= r_empty;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/histogram_exposure_statistics.sv =====
// Channel   Dir   Word
// i_bin     in    bin_count, last_bin, frame_time (one histogram bin, lowest first)
// o_lvl     out   mean_level, peak_level, key_level, bloom_level, empty_frame
// APB       in    max_level, adapt_rate, percentile_target, bloom_fraction at 0x0..0xC
//
// Bins are taken one per cycle while a queue slot is free; the front end stores
// them and keeps running sums. In the back end, a frame goes through a key scan
// that reads and then checks each bin, a shift-add multiply and the one-bit-per-cycle
// mean divider; an empty frame goes straight to the result register.
// Two frame summaries can wait, so the next histogram loads while one is worked on.
// Reset is synchronous and active low; no clearing pass is needed.
// A stalled result stays in the output register while the next frame is processed.
module histogram_exposure_statistics #(
    parameter int unsigned BIN_COUNT  = hes_pkg::BIN_COUNT_DEF,
    parameter int unsigned COUNT_BITS = hes_pkg::COUNT_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    hes_bin_if.sink                     i_bin,
    hes_lvl_if.source                   o_lvl,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [hes_pkg::APB_AW-1:0]  paddr,
    input  logic [hes_pkg::APB_DW-1:0]  pwdata,
    output logic [hes_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);
    import hes_pkg::*;

    localparam int unsigned IDX_W = $clog2(BIN_COUNT);
    localparam int unsigned TOT_W = COUNT_BITS + IDX_W;
    localparam int unsigned WGT_W = COUNT_BITS + 2 * IDX_W;
    localparam int unsigned JOB_W = 1 + IDX_W + TOT_W + WGT_W + IDX_W + FT_W;

    t_cfg                  r_cfg;
    t_reg_idx              reg_idx;
    logic                  wr_acc;
    t_q_stat               q_stat;
    logic                  push;
    logic                  pop;
    logic [JOB_W-1:0]      job_in;
    logic [JOB_W-1:0]      job_head;
    logic                  wr_en;
    logic [IDX_W:0]        wr_addr;
    logic [COUNT_BITS-1:0] wr_data;

    // Register file access.
    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[3:2]);
    assign wr_acc  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_level         <= MAX_LEVEL_RST;
            r_cfg.adapt_rate        <= ADAPT_RATE_RST;
            r_cfg.percentile_target <= PCT_TARGET_RST;
            r_cfg.bloom_fraction    <= BLOOM_FRAC_RST;
        end else if (wr_acc) begin
            case (reg_idx)
                REG_MAX_LEVEL:  r_cfg.max_level         <= pwdata[15:0];
                REG_ADAPT_RATE: r_cfg.adapt_rate        <= pwdata[15:0];
                REG_PCT_TARGET: r_cfg.percentile_target <= pwdata[15:0];
                REG_BLOOM_FRAC: r_cfg.bloom_fraction    <= pwdata[15:0];
                default:        r_cfg.max_level         <= r_cfg.max_level;
            endcase
        end
    end

    // Read back.
    always_comb begin
        case (reg_idx)
            REG_MAX_LEVEL:  prdata = {16'h0000, r_cfg.max_level};
            REG_ADAPT_RATE: prdata = {16'h0000, r_cfg.adapt_rate};
            REG_PCT_TARGET: prdata = {16'h0000, r_cfg.percentile_target};
            REG_BLOOM_FRAC: prdata = {16'h0000, r_cfg.bloom_fraction};
            default:        prdata = '0;
        endcase
    end

    // Bin intake and per-frame sums.
    hes_front #(
        .BIN_COUNT  (BIN_COUNT),
        .COUNT_BITS (COUNT_BITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_bin     (i_bin),
        .i_q_stat  (q_stat),
        .o_push    (push),
        .o_job     (job_in),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_wr_data (wr_data)
    );

    // Closed frames waiting for the back end.
    hes_queue #(
        .W (JOB_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .i_data  (job_in),
        .o_stat  (q_stat),
        .o_head  (job_head)
    );

    // Level computation, smoothing and result register.
    hes_back #(
        .BIN_COUNT  (BIN_COUNT),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_q_stat  (q_stat),
        .i_job     (job_head),
        .o_pop     (pop),
        .o_lvl     (o_lvl)
    );

endmodule

// ===== dv/histogram_exposure_statistics_tb.sv =====
module histogram_exposure_statistics_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hes_pkg::*;

    localparam int unsigned NBINS         = BIN_COUNT_DEF;
    localparam int unsigned CBITS         = COUNT_BITS_DEF;
    localparam int unsigned IDLE_PCT      = 29;
    localparam int unsigned PHASE_ITEMS   = 180;
    localparam int unsigned NUM_PHASES    = 6;
    localparam int unsigned SETTLE_CYCLES = 150;
    localparam int unsigned STALL_LIMIT   = 4000;

    // One result word: the four smoothed levels and the empty flag.
    typedef struct packed {
        logic [LVL_W-1:0] mean;
        logic [LVL_W-1:0] peak;
        logic [LVL_W-1:0] key;
        logic [LVL_W-1:0] bloom;
        logic             empty;
    } t_level_word;

    // One bin word, with an optional typed-in result for the frame it closes.
    typedef struct packed {
        logic [CBITS-1:0] count;
        logic             last;
        logic [FT_W-1:0]  ft;
        logic             pinned;
        t_level_word      pinned_word;
    } t_bin_word;

    localparam t_level_word NO_WORD    = '0;
    localparam t_level_word HELD_EMPTY =
        '{SM_MEAN_RST, SM_PEAK_RST, SM_KEY_RST, SM_BLOOM_RST, 1'b1};
    localparam t_level_word HELD_FULL  =
        '{SM_MEAN_RST, SM_PEAK_RST, SM_KEY_RST, SM_BLOOM_RST, 1'b0};

    // Directed frames: empty histogram, zero frame time, empty short frame,
    // saturated blend weight, tiny weight, and a frame of a single occupied bin.
    localparam t_bin_word DIRECTED_ROWS [12] = '{
        '{24'h000000, 1'b1, 16'hFFFF, 1'b1, HELD_EMPTY},
        '{24'hFFFFFF, 1'b1, 16'h0000, 1'b1, HELD_FULL},
        '{24'h000000, 1'b0, 16'h1234, 1'b0, NO_WORD},
        '{24'h000000, 1'b0, 16'hFFFF, 1'b0, NO_WORD},
        '{24'h000000, 1'b1, 16'hFFFF, 1'b1, HELD_EMPTY},
        '{24'hFFFFFF, 1'b0, 16'h0000, 1'b0, NO_WORD},
        '{24'h000000, 1'b0, 16'h0000, 1'b0, NO_WORD},
        '{24'h800000, 1'b0, 16'h0000, 1'b0, NO_WORD},
        '{24'h000001, 1'b1, 16'hFFFF, 1'b0, NO_WORD},
        '{24'h000001, 1'b0, 16'h0000, 1'b0, NO_WORD},
        '{24'h000000, 1'b1, 16'h0001, 1'b0, NO_WORD},
        '{24'h000005, 1'b1, 16'h8000, 1'b0, NO_WORD}
    };

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_AW-1:0]     paddr;
    logic [APB_DW-1:0]     pwdata;
    logic [APB_DW-1:0]     prdata;
    logic                  pready;

    hes_bin_if #(.COUNT_BITS(CBITS)) bin_ch ();
    hes_lvl_if                       lvl_ch ();

    histogram_exposure_statistics #(
        .BIN_COUNT (NBINS),
        .COUNT_BITS(CBITS)
    ) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_bin  (bin_ch.sink),
        .o_lvl  (lvl_ch.source),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready)
    );

    // Shadow of the block: stored bins, write position, smoothed levels, registers.
    logic [CBITS-1:0] hist_bins [NBINS];
    int unsigned      hist_pos = 0;
    logic [LVL_W-1:0] sm_mean  = SM_MEAN_RST;
    logic [LVL_W-1:0] sm_peak  = SM_PEAK_RST;
    logic [LVL_W-1:0] sm_key   = SM_KEY_RST;
    logic [LVL_W-1:0] sm_bloom = SM_BLOOM_RST;
    t_cfg             cfg      = '{MAX_LEVEL_RST, ADAPT_RATE_RST, PCT_TARGET_RST, BLOOM_FRAC_RST};

    t_level_word      level_exp_q [$];
    t_bin_word        cur_word;
    bit               steady = 1'b0;
    int unsigned      mismatch_count = 0;
    int unsigned      stall_cycles = 0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
        $display("ERROR at %0t ns: %s got %0d expected %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // Exponential blend of one smoothed level toward its new value, rounded.
    function automatic logic [LVL_W-1:0] blend_level(logic [LVL_W-1:0] prev,
                                                     logic [LVL_W-1:0] target,
                                                     bit [63:0] wgt);
        bit [63:0] acc;
        acc = 64'(prev) * (64'd65536 - wgt) + 64'(target) * wgt + 64'd32768;
        return acc[31:16];
    endfunction

    // Stores one bin; on the last bin works out the frame statistics and the
    // smoothed levels, and queues the word the block should send.
    task automatic absorb_bin(t_bin_word w);
        int unsigned pos;
        int unsigned used;
        int unsigned top;
        int unsigned k;
        bit          found;
        bit [63:0]   total;
        bit [63:0]   weighted;
        bit [63:0]   q;
        bit [63:0]   r;
        bit [63:0]   tgt;
        bit [63:0]   cum;
        bit [63:0]   wgt;
        bit [63:0]   mean;
        bit [63:0]   peak;
        bit [63:0]   key;
        bit [63:0]   bloom;
        t_level_word word;
        pos = hist_pos;
        hist_bins[pos] = w.count;
        if (!w.last) begin
            hist_pos = (pos + 1) % NBINS;
            return;
        end
        hist_pos = 0;
        used = pos + 1;
        total = 0;
        weighted = 0;
        for (int i = 0; i < used; i++) begin
            total += hist_bins[i];
            weighted += 64'(hist_bins[i]) * i;
        end
        if (total != 0) begin
            q = weighted / total;
            r = weighted % total;
            mean = (q * cfg.max_level + (r * cfg.max_level) / total) / NBINS;

            top = used - 1;
            while (top > 0 && hist_bins[top] == 0) top--;
            peak = (64'(top) * cfg.max_level) / NBINS;

            // Walk down from the top until the upper tail holds enough pixels.
            tgt = total * (64'd65536 - cfg.percentile_target);
            cum = 0;
            k = used - 1;
            found = 1'b0;
            while (!found) begin
                cum += hist_bins[k];
                if ((cum << 16) >= tgt || k == 0) found = 1'b1;
                else k--;
            end
            key = (64'(k + 1) * cfg.max_level) / NBINS;
            bloom = (key * cfg.bloom_fraction) >> 16;

            wgt = (64'(w.ft) * cfg.adapt_rate) >> 12;
            if (wgt > 64'd65536) wgt = 64'd65536;

            sm_mean  = blend_level(sm_mean, mean[15:0], wgt);
            sm_peak  = blend_level(sm_peak, peak[15:0], wgt);
            sm_key   = blend_level(sm_key, key[15:0], wgt);
            sm_bloom = blend_level(sm_bloom, bloom[15:0], wgt);
        end
        word = '{sm_mean, sm_peak, sm_key, sm_bloom, total == 0};
        level_exp_q.push_back(w.pinned ? w.pinned_word : word);
    endtask

    // Accepted bin words feed the shadow model.
    always @(posedge i_clk) begin
        if (i_rst_n && bin_ch.valid && bin_ch.ready) begin
            absorb_bin(cur_word);
        end
    end

    // Accepted result words are checked against the oldest expectation.
    always @(posedge i_clk) begin
        t_level_word want;
        if (i_rst_n && lvl_ch.valid && lvl_ch.ready) begin
            if (level_exp_q.size() == 0) begin
                report_mismatch("result word with nothing expected, mean", lvl_ch.mean_level, 0);
            end else begin
                want = level_exp_q.pop_front();
                if (lvl_ch.mean_level !== want.mean)
                    report_mismatch("mean_level", lvl_ch.mean_level, want.mean);
                if (lvl_ch.peak_level !== want.peak)
                    report_mismatch("peak_level", lvl_ch.peak_level, want.peak);
                if (lvl_ch.key_level !== want.key)
                    report_mismatch("key_level", lvl_ch.key_level, want.key);
                if (lvl_ch.bloom_level !== want.bloom)
                    report_mismatch("bloom_level", lvl_ch.bloom_level, want.bloom);
                if (lvl_ch.empty_frame !== want.empty)
                    report_mismatch("empty_frame", lvl_ch.empty_frame, want.empty);
            end
        end
    end

    // The result side stalls at random unless a steady stretch is running.
    always @(negedge i_clk) begin
        lvl_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    // Watchdog on cycles with no word accepted on either channel.
    always @(posedge i_clk) begin
        if ((bin_ch.valid && bin_ch.ready) || (lvl_ch.valid && lvl_ch.ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("histogram_exposure_statistics test failed");
            $finish;
        end
    end

    function automatic bit take_gap();
        return !steady && ($urandom_range(99) < IDLE_PCT);
    endfunction

    // Presents one bin word and holds it until accepted; entered and left
    // just after a falling edge.
    task automatic drive_bin(t_bin_word w);
        while (take_gap()) begin
            bin_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        cur_word = w;
        bin_ch.valid      <= 1'b1;
        bin_ch.bin_count  <= w.count;
        bin_ch.last_bin   <= w.last;
        bin_ch.frame_time <= w.ft;
        do @(posedge i_clk); while (!bin_ch.ready);
        @(negedge i_clk);
    endtask

    // Writes a register, updates the shadow copy, and reads it back.
    task automatic program_reg(t_reg_idx idx, logic [15:0] val);
        logic [APB_DW-1:0] got;
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'h0000, val};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_MAX_LEVEL:  cfg.max_level = val;
            REG_ADAPT_RATE: cfg.adapt_rate = val;
            REG_PCT_TARGET: cfg.percentile_target = val;
            REG_BLOOM_FRAC: cfg.bloom_fraction = val;
            default: ;
        endcase
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        got = prdata;
        if (got[15:0] !== val) report_mismatch("register read back", got, val);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Waits for every expected word, then lets the back end go quiet.
    task automatic settle();
        while (level_exp_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic logic [CBITS-1:0] random_count();
        case ($urandom_range(9))
            0, 1, 2, 3: return '0;
            4, 5:       return CBITS'($urandom_range(255));
            6, 7:       return CBITS'($urandom);
            8:          return '1;
            default:    return CBITS'($urandom_range(65535));
        endcase
    endfunction

    function automatic logic [FT_W-1:0] random_frame_time();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2, 3, 4: return FT_W'($urandom_range(64, 1));
            default: return FT_W'($urandom);
        endcase
    endfunction

    // One frame: mostly full histograms, some short, some that wrap around.
    task automatic send_random_frame(inout int unsigned sent);
        int unsigned len;
        int unsigned shape;
        bit          hollow;
        t_bin_word   w;
        shape = $urandom_range(99);
        if (shape < 60) len = NBINS;
        else if (shape < 85) len = $urandom_range(NBINS - 1, 1);
        else len = $urandom_range(3 * NBINS, NBINS + 1);
        hollow = ($urandom_range(99) < 8);
        for (int i = 0; i < len; i++) begin
            w.count       = hollow ? '0 : random_count();
            w.last        = (i == len - 1);
            w.ft          = w.last ? random_frame_time() : FT_W'($urandom);
            w.pinned      = 1'b0;
            w.pinned_word = NO_WORD;
            drive_bin(w);
            sent++;
        end
    endtask

    initial begin
        t_cfg        plan;
        int unsigned sent;
        i_rst_n           = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        bin_ch.valid      = 1'b0;
        bin_ch.bin_count  = '0;
        bin_ch.last_bin   = 1'b0;
        bin_ch.frame_time = '0;
        lvl_ch.ready      = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed frames under the reset settings.
        foreach (DIRECTED_ROWS[i]) drive_bin(DIRECTED_ROWS[i]);
        bin_ch.valid <= 1'b0;

        // Random phases, each under its own register settings.
        for (int p = 0; p < NUM_PHASES; p++) begin
            settle();
            case (p)
                0: plan = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
                1: plan = '{16'd1, 16'd0, 16'd0, 16'd0};
                2: plan = '{16'd0, 16'd4096, 16'd32768, 16'd65535};
                default: plan = '{16'($urandom_range(65535, 1)), 16'($urandom),
                                  16'($urandom), 16'($urandom)};
            endcase
            program_reg(REG_MAX_LEVEL, plan.max_level);
            program_reg(REG_ADAPT_RATE, plan.adapt_rate);
            program_reg(REG_PCT_TARGET, plan.percentile_target);
            program_reg(REG_BLOOM_FRAC, plan.bloom_fraction);
            @(negedge i_clk);
            steady = (p == 4);
            sent = 0;
            while (sent < PHASE_ITEMS) send_random_frame(sent);
            bin_ch.valid <= 1'b0;
        end
        steady = 1'b0;

        // Drain the remaining results and give the block time to stay quiet.
        while (level_exp_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("histogram_exposure_statistics test passed");
        end else begin
            $display("histogram_exposure_statistics test failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/hes_pkg.sv
rtl/hes_if.sv
rtl/hes_queue.sv
rtl/hes_front.sv
rtl/hes_back.sv
rtl/histogram_exposure_statistics.sv
dv/histogram_exposure_statistics_tb.sv
